@@ rtl/core/i2p_pkg.sv @@
// shared types, constants and helper functions for the infix to postfix converter
// used by i2p_ctrl, i2p_dp and infix_to_postfix_converter_core
// no dependencies
package i2p_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;
    localparam int ERR_W       = 2;
    localparam int RANK_W      = 3;

    // characters with a meaning of their own
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] CH_0     = 8'h30;
    localparam logic [SYM_W-1:0] CH_9     = 8'h39;
    localparam logic [SYM_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LC_Z  = 8'h7A;

    localparam logic [RANK_W-1:0] RANK_MULDIV = 3'd5;
    localparam logic [RANK_W-1:0] RANK_ADDSUB = 3'd4;
    localparam logic [RANK_W-1:0] RANK_OTHER  = 3'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

    // result source select
    localparam logic [1:0] SEL_TOP = 2'd0;
    localparam logic [1:0] SEL_SYM = 2'd1;
    localparam logic [1:0] SEL_ERR = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic             load;   // latch the input request
        logic             pop;    // drop the top of stack
        logic             push;   // push the latched symbol
        logic             emit;   // produce one result
        logic [1:0]       sel;    // source of the produced result
        logic [ERR_W-1:0] err;    // error code of an error result
        logic             fin;    // close the run with the last result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_end;
        logic is_alnum;
        logic is_open;
        logic is_close;
        logic empty;
        logic full;
        logic top_is_open;
        logic top_ge;       // rank of top at least the rank of the symbol
        logic pend_valid;
        logic out_free;
    } t_dp_sts;

    function automatic logic [RANK_W-1:0] rank_of(input logic [SYM_W-1:0] c);
        logic [RANK_W-1:0] r;
        if (c == CH_MUL || c == CH_DIV) begin
            r = RANK_MULDIV;
        end else if (c == CH_ADD || c == CH_SUB) begin
            r = RANK_ADDSUB;
        end else begin
            r = RANK_OTHER;
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_LC_A && c <= CH_LC_Z);
    endfunction

endpackage

@@ rtl/core/i2p_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/i2p_ctrl.sv @@
// controller state machine for the infix to postfix converter
// depends on i2p_pkg
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STEP   = 2'd1;
    localparam logic [1:0] S_REREAD = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_dp_cmd    cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.out_free) begin
                    priority if (i_sts.is_end) begin
                        if (i_sts.empty) begin
                            cmd.fin = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            // open parentheses are dropped silently
                            cmd.pop  = 1'b1;
                            cmd.emit = !i_sts.top_is_open;
                            cmd.sel  = SEL_TOP;
                            n_state  = S_REREAD;
                        end
                    end else if (i_sts.is_alnum) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_SYM;
                        cmd.fin  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_sts.is_close) begin
                        if (i_sts.empty) begin
                            cmd.emit = 1'b1;
                            cmd.sel  = SEL_ERR;
                            cmd.err  = ERR_UNMATCHED;
                            cmd.fin  = !i_sts.pend_valid;
                            n_state  = i_sts.pend_valid ? S_FIN : S_IDLE;
                        end else if (i_sts.top_is_open) begin
                            cmd.pop = 1'b1;
                            cmd.fin = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                            cmd.sel  = SEL_TOP;
                            n_state  = S_REREAD;
                        end
                    end else if (!i_sts.is_open && !i_sts.empty &&
                                 !i_sts.top_is_open && i_sts.top_ge) begin
                        // operator pops a stacked operator of equal or higher rank
                        cmd.pop  = 1'b1;
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_TOP;
                        n_state  = S_REREAD;
                    end else if (i_sts.full) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_ERR;
                        cmd.err  = ERR_OVERFLOW;
                        cmd.fin  = !i_sts.pend_valid;
                        n_state  = i_sts.pend_valid ? S_FIN : S_IDLE;
                    end else begin
                        cmd.push = 1'b1;
                        cmd.fin  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_REREAD: begin
                n_state = S_STEP;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

@@ rtl/core/i2p_dp.sv @@
// datapath: latched request, operator stack, pending result and output register
// depends on i2p_pkg and i2p_ram
module i2p_dp
    import i2p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_end_mark,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [SYM_W-1:0] o_out_symbol,
    output logic             o_out_has,
    output logic [ERR_W-1:0] o_out_err,
    output logic             o_out_last
);

    logic [SYM_W-1:0] r_sym;
    logic             r_end;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] count_m1;
    logic [SYM_W-1:0] top;

    logic             r_pend_valid;
    logic [SYM_W-1:0] r_pend_sym;
    logic             r_pend_has;
    logic [ERR_W-1:0] r_pend_err;

    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_has;
    logic [ERR_W-1:0] r_out_err;
    logic             r_out_last;

    logic [SYM_W-1:0] x_sym;
    logic             x_has;
    logic [ERR_W-1:0] x_err;
    logic             out_load;
    logic             out_free;

    assign count_m1 = r_count - CNT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    i2p_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_sym),
        .i_raddr (count_m1[ADDR_W-1:0]),
        .o_rdata (top)
    );

    // result being produced this cycle
    always_comb begin
        x_sym = '0;
        x_has = 1'b0;
        x_err = ERR_NONE;
        unique case (i_cmd.sel)
            SEL_TOP: begin
                x_sym = top;
                x_has = 1'b1;
            end
            SEL_SYM: begin
                x_sym = r_sym;
                x_has = 1'b1;
            end
            SEL_ERR: begin
                x_err = i_cmd.err;
            end
            default: begin
                x_err = ERR_NONE;
            end
        endcase
    end

    assign out_load = i_cmd.fin || (i_cmd.emit && r_pend_valid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_symbol;
            r_end <= i_end_mark;
        end
        if (i_cmd.emit && !i_cmd.fin) begin
            r_pend_sym <= x_sym;
            r_pend_has <= x_has;
            r_pend_err <= x_err;
        end
        if (out_load) begin
            if (i_cmd.emit && i_cmd.fin) begin
                r_out_sym  <= x_sym;
                r_out_has  <= x_has;
                r_out_err  <= x_err;
            end else if (r_pend_valid) begin
                r_out_sym  <= r_pend_sym;
                r_out_has  <= r_pend_has;
                r_out_err  <= r_pend_err;
            end else begin
                r_out_sym  <= '0;
                r_out_has  <= 1'b0;
                r_out_err  <= ERR_NONE;
            end
            r_out_last <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= count_m1;
            end
            if (i_cmd.fin) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.is_end      = r_end;
        o_sts.is_alnum    = is_alnum(r_sym);
        o_sts.is_open     = (r_sym == CH_OPEN);
        o_sts.is_close    = (r_sym == CH_CLOSE);
        o_sts.empty       = (r_count == '0);
        o_sts.full        = (r_count == CNT_W'(STACK_DEPTH));
        o_sts.top_is_open = (top == CH_OPEN);
        o_sts.top_ge      = (rank_of(top) >= rank_of(r_sym));
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_free    = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_sym;
    assign o_out_has    = r_out_has;
    assign o_out_err    = r_out_err;
    assign o_out_last   = r_out_last;

endmodule

@@ rtl/core/infix_to_postfix_converter_core.sv @@
// top level of the infix to postfix converter (shunting-yard)
// depends on i2p_pkg, i2p_ctrl, i2p_dp and i2p_ram
//
// Takes one ASCII character per request and emits the postfix form, one character
// per result request. Letters and digits go straight through, '(' is stacked, ')'
// unwinds to its '(' and operators pop stacked operators of equal or higher rank
// ('*' '/' above '+' '-' above everything else) before being stacked. A request with
// tlast set flushes the stack and ignores its data. Every request gives at least
// one result, and the last result it causes has tlast set; a request that emits no
// character gives a single empty result. Errors (stack full, unmatched ')') come as
// an empty result carrying the error code. Requests are taken one at a time: a
// letter, a digit, '(' or an operator that pops nothing takes 2 cycles, each
// stack entry popped adds 2 cycles because the new top must be read back from the
// registered-read stack ram (the '(' removed by its ')' adds nothing, it is popped
// in the closing cycle), and an error result that follows popped characters
// adds 1 cycle. Back-pressure on the result side stretches these figures. The
// stack holds STACK_DEPTH entries and needs no clearing after reset.
module infix_to_postfix_converter_core
    import i2p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [SYM_W-1:0] s_axis_tdata,   // [7:0] symbol
    input  logic             s_axis_tlast,   // end_mark
    // result requests
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [SYM_W-1:0] m_axis_tdata,   // [7:0] out_symbol
    output logic [ERR_W:0]   m_axis_tuser,   // [0] has_symbol, [2:1] error_code
    output logic             m_axis_tlast    // last_of_run
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             out_has;
    logic [ERR_W-1:0] out_err;

    // sequencing of each request
    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // stack, pending result and output register
    i2p_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_symbol     (s_axis_tdata),
        .i_end_mark   (s_axis_tlast),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_symbol (m_axis_tdata),
        .o_out_has    (out_has),
        .o_out_err    (out_err),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {out_err, out_has};

    // never push onto a full stack
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !sts.full)
        else $error("push on full stack");

    // never pop an empty stack
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !sts.empty)
        else $error("pop on empty stack");

    // a direct last result must not overtake a pending one
    a_no_lost_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.fin) |-> !sts.pend_valid)
        else $error("pending result lost");

    // a result carrying a character never carries an error
    a_char_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[ERR_W:1] == ERR_NONE))
        else $error("character result with error code");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for infix_to_postfix_converter_core: directed expressions,
// stack overflow runs and random expressions under varying stream back-pressure
// depends on i2p_pkg and the converter rtl
module tb
    import i2p_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_BUDGET  = 125;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             has;
        logic [ERR_W-1:0] err;
        logic             last;
    } t_postfix_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [SYM_W-1:0] s_axis_tdata  = '0;   // [7:0] symbol
    logic             s_axis_tlast  = 1'b0; // end_mark
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [SYM_W-1:0] m_axis_tdata;         // [7:0] out_symbol
    logic [ERR_W:0]   m_axis_tuser;         // [0] has_symbol, [2:1] error_code
    logic             m_axis_tlast;         // last_of_run

    // shadow of the operator stack
    logic [SYM_W-1:0] op_stack [STACK_DEPTH];
    int unsigned      op_depth = 0;

    t_postfix_result  expected_results [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int overflow_flags  = 0;
    int unmatched_flags = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    infix_to_postfix_converter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int precedence(input logic [SYM_W-1:0] c);
        if (c == CH_MUL || c == CH_DIV) begin
            return 5;
        end
        if (c == CH_ADD || c == CH_SUB) begin
            return 4;
        end
        return 3;
    endfunction

    function automatic logic is_operand(input logic [SYM_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_LC_A && c <= CH_LC_Z);
    endfunction

    function automatic t_postfix_result char_result(input logic [SYM_W-1:0] c);
        t_postfix_result r;
        r.sym  = c;
        r.has  = 1'b1;
        r.err  = ERR_NONE;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_postfix_result flag_result(input logic [ERR_W-1:0] code);
        t_postfix_result r;
        r.sym  = '0;
        r.has  = 1'b0;
        r.err  = code;
        r.last = 1'b0;
        return r;
    endfunction

    // returns 0 when the stack is full and the symbol is dropped
    function automatic logic stack_push(input logic [SYM_W-1:0] c);
        if (op_depth >= STACK_DEPTH) begin
            return 1'b0;
        end
        op_stack[op_depth] = c;
        op_depth++;
        return 1'b1;
    endfunction

    // works out the results one request causes and queues them
    function automatic void predict_postfix(input logic [SYM_W-1:0] sym, input logic endm);
        t_postfix_result emitted [$];
        logic             found;
        int               prec;
        found = 1'b0;
        prec  = precedence(sym);
        if (endm) begin
            // flush, open parens vanish silently
            while (op_depth > 0) begin
                op_depth--;
                if (op_stack[op_depth] != CH_OPEN) begin
                    emitted.push_back(char_result(op_stack[op_depth]));
                end
            end
        end else if (is_operand(sym)) begin
            emitted.push_back(char_result(sym));
        end else if (sym == CH_OPEN) begin
            if (!stack_push(sym)) begin
                emitted.push_back(flag_result(ERR_OVERFLOW));
            end
        end else if (sym == CH_CLOSE) begin
            while (op_depth > 0 && !found) begin
                op_depth--;
                if (op_stack[op_depth] == CH_OPEN) begin
                    found = 1'b1;
                end else begin
                    emitted.push_back(char_result(op_stack[op_depth]));
                end
            end
            if (!found) begin
                emitted.push_back(flag_result(ERR_UNMATCHED));
            end
        end else begin
            // pop equal or higher rank, never past an open paren
            while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN &&
                   precedence(op_stack[op_depth-1]) >= prec) begin
                op_depth--;
                emitted.push_back(char_result(op_stack[op_depth]));
            end
            if (!stack_push(sym)) begin
                emitted.push_back(flag_result(ERR_OVERFLOW));
            end
        end
        if (emitted.size() == 0) begin
            emitted.push_back(flag_result(ERR_NONE));
        end
        emitted[emitted.size()-1].last = 1'b1;
        foreach (emitted[i]) begin
            expected_results.push_back(emitted[i]);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_postfix_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %h user %h last %b",
                                      m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
            want = expected_results.pop_front();
            if (m_axis_tdata !== want.sym) begin
                report_mismatch($sformatf("result %0d out_symbol %h, expected %h",
                                          results_checked, m_axis_tdata, want.sym));
            end
            if (m_axis_tuser[0] !== want.has) begin
                report_mismatch($sformatf("result %0d has_symbol %b, expected %b",
                                          results_checked, m_axis_tuser[0], want.has));
            end
            if (m_axis_tuser[ERR_W:1] !== want.err) begin
                report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                          results_checked, m_axis_tuser[ERR_W:1], want.err));
            end
            if (m_axis_tlast !== want.last) begin
                report_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                          results_checked, m_axis_tlast, want.last));
            end
            if (want.err == ERR_OVERFLOW) begin
                overflow_flags++;
            end
            if (want.err == ERR_UNMATCHED) begin
                unmatched_flags++;
            end
        end
        results_checked++;
    endtask

    // handshakes are sampled mid-cycle, where nothing moves
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result();
        end
    end

    always @(negedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [SYM_W-1:0] random_operand();
        logic [SYM_W-1:0] c;
        case ($urandom_range(2))
            0:       c = CH_0 + SYM_W'($urandom_range(9));
            1:       c = CH_UC_A + SYM_W'($urandom_range(25));
            default: c = CH_LC_A + SYM_W'($urandom_range(25));
        endcase
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        logic [SYM_W-1:0] c;
        case ($urandom_range(5))
            0: c = CH_MUL;
            1: c = CH_DIV;
            2: c = CH_ADD;
            3: c = CH_SUB;
            default: begin
                // any other byte that is neither operand nor paren
                c = SYM_W'($urandom_range(255));
                while (is_operand(c) || c == CH_OPEN || c == CH_CLOSE) begin
                    c = SYM_W'($urandom_range(255));
                end
            end
        endcase
        return c;
    endfunction

    // valid stays high across back-to-back requests, lowered only on a gap
    task automatic send_request(input logic [SYM_W-1:0] sym, input logic endm);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= endm;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end
        predict_postfix(sym, endm);
        items_sent++;
    endtask

    task automatic send_infix(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_request(SYM_W'(text[i]), 1'b0);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_directed_cases();
        send_request("x", 1'b1);        // end on an empty stack, data ignored
        send_request(CH_CLOSE, 1'b0);   // close with nothing stacked
        send_infix("0+9*Z/(A-z)");      // operand extremes, all four arithmetic ops
        send_request(8'hFF, 1'b0);      // low rank op pops everything
        send_request("a", 1'b0);
        send_request(8'h00, 1'b0);      // equal low rank pops the previous one
        send_request(CH_OPEN, 1'b0);
        send_request(8'hFF, 1'b1);      // flush drops the leftover open paren
        send_infix("b-)");              // unmatched close after popping an op
        send_request(8'h80, 1'b1);
    endtask

    task automatic test_stack_overflow();
        for (int k = 0; k < STACK_DEPTH / 2; k++) begin
            send_request(CH_OPEN, 1'b0);
            send_request(random_operator(), 1'b0);
        end
        send_request(CH_OPEN, 1'b0);            // full stack, dropped with a flag
        send_request(random_operand(), 1'b0);
        send_request(random_operator(), 1'b0);  // pops the top or is dropped
        send_request(CH_CLOSE, 1'b0);
        send_request(SYM_W'($urandom_range(255)), 1'b1);
    endtask

    // mostly well-formed expressions, some with noise and missing pieces
    task automatic test_random_expressions(input int budget);
        int   start;
        int   opens;
        int   terms;
        logic broken;
        start = items_sent;
        while (items_sent - start < budget) begin
            opens  = 0;
            terms  = $urandom_range(1, 6);
            broken = ($urandom_range(99) < 15);
            for (int k = 0; k < terms; k++) begin
                while ($urandom_range(99) < 25 && opens < 20) begin
                    send_request(CH_OPEN, 1'b0);
                    opens++;
                end
                repeat ($urandom_range(1, 2)) send_request(random_operand(), 1'b0);
                while (opens > 0 && $urandom_range(99) < 30) begin
                    send_request(CH_CLOSE, 1'b0);
                    opens--;
                end
                if (broken && $urandom_range(99) < 40) begin
                    if ($urandom_range(1) == 0) begin
                        send_request(CH_CLOSE, 1'b0);
                    end else begin
                        send_request(SYM_W'($urandom_range(255)), 1'b0);
                    end
                end
                if (k < terms - 1) begin
                    send_request(random_operator(), 1'b0);
                end
            end
            if (!broken) begin
                while (opens > 0) begin
                    send_request(CH_CLOSE, 1'b0);
                    opens--;
                end
            end
            if (!broken || $urandom_range(1) == 0) begin
                send_request(SYM_W'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(24, 50);
        test_directed_cases();
        test_stack_overflow();
        test_random_expressions(RANDOM_BUDGET);
        set_idling(50, 24);
        test_random_expressions(RANDOM_BUDGET);
        set_idling(0, 0);
        test_stack_overflow();
        test_random_expressions(RANDOM_BUDGET);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results", items_sent, results_checked);
        $display("saw %0d overflow and %0d unmatched-close flags, %0d mismatches",
                 overflow_flags, unmatched_flags, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/i2p_pkg.sv
rtl/core/i2p_ram.sv
rtl/core/i2p_ctrl.sv
rtl/core/i2p_dp.sv
rtl/core/infix_to_postfix_converter_core.sv
tb/tb.sv
